FILE: rtl/core/paeg_pkg.sv
// Shared constants, payload types and state codes of the preferential attachment generator.
package paeg_pkg;

  // Store sizes.
  localparam int MAX_VERTICES = 16384;
  localparam int MAX_EDGES    = 32768;

  // Address and counter widths that follow from the store sizes.
  localparam int VTX_AW = $clog2(MAX_VERTICES);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int EC_W = $clog2(MAX_EDGES + 1);

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int VTX_W      = 14;
  localparam int RND_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int DEG_W      = 16;
  localparam int TOTAL_W    = 16;
  localparam int NV_W       = 15;
  localparam int PER_W      = 4;
  localparam int DRAW_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Register values after reset and the draw count limits.
  localparam logic [NV_W-1:0]  SEED_NODES_RESET     = NV_W'(100);
  localparam logic [PER_W-1:0] EDGES_PER_NODE_RESET = PER_W'(2);
  localparam logic [PER_W-1:0] PER_MIN              = PER_W'(1);
  localparam logic [PER_W-1:0] PER_MAX              = PER_W'(8);

  // Remainder unit: bits retired per cycle and cycles per operation.
  localparam int DIV_STEP   = 2;
  localparam int DIV_CYCLES = RND_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEED_NODES     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EDGES_PER_NODE = CFG_IDX_W'(1);

  typedef logic [VTX_AW-1:0]  vtx_addr_t;
  typedef logic [EDGE_AW-1:0] edge_addr_t;
  typedef logic [EC_W-1:0]    edge_cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_SEED   = 2'd0,
    OP_ATTACH = 2'd1,
    OP_DEGREE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_LIMIT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_EDGE_RD,
    ST_EDGE_DATA,
    ST_APPEND,
    ST_DEG_RD_A,
    ST_DEG_WR_A,
    ST_DEG_RD_B,
    ST_DEG_WR_B,
    ST_QUERY_RD,
    ST_QUERY_DATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [VTX_W-1:0] end_a;
    logic [VTX_W-1:0] end_b;
    logic [RND_W-1:0] random_word;
    logic             pick_first;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VTX_W-1:0]    edge_from;
    logic [VTX_W-1:0]    edge_to;
    logic [DEG_W-1:0]    degree;
    logic [TOTAL_W-1:0]  edge_total;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

  // One word of the edge store.
  typedef struct packed {
    logic [VTX_W-1:0] first_end;
    logic [VTX_W-1:0] second_end;
  } edge_word_t;

endpackage

FILE: rtl/core/paeg_if.sv
// Valid/ready channel interfaces for input items, result items and register writes.
interface paeg_in_if;
  logic                valid;
  logic                ready;
  paeg_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface paeg_out_if;
  logic                valid;
  logic                ready;
  paeg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface paeg_cfg_if;
  logic                 valid;
  logic                 ready;
  paeg_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/paeg_mod_unit.sv
// Iterative remainder unit: a 32-bit word modulo the edge count, two bits per cycle.
module paeg_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [paeg_pkg::RND_W-1:0] dividend_i,
  input  paeg_pkg::edge_cnt_t        divisor_i,
  output logic                       done_o,
  output paeg_pkg::edge_cnt_t        rem_o
);

  logic [paeg_pkg::RND_W-1:0]     dvd_q, dvd_d;
  paeg_pkg::edge_cnt_t            dsr_q, dsr_d;
  paeg_pkg::edge_cnt_t            rem_q, rem_d;
  logic [paeg_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  paeg_pkg::edge_cnt_t            step_rem;
  logic [paeg_pkg::EC_W:0]        trial;

  // Restoring steps of this cycle; the partial remainder always stays below the divisor.
  always_comb begin
    step_rem = rem_q;
    for (int i = 0; i < paeg_pkg::DIV_STEP; i++) begin
      trial = {step_rem, dvd_q[paeg_pkg::RND_W-1-i]};
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      step_rem = trial[paeg_pkg::EC_W-1:0];
    end
  end

  // Sequencing of one operation.
  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      dvd_d = dvd_q << paeg_pkg::DIV_STEP;
      rem_d = step_rem;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == paeg_pkg::DIV_CNT_W'(paeg_pkg::DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/preferential_attachment_edge_generator_core.sv
// Top level: edge store, degree store, sequencer and result register of the graph generator.
// A refused or unknown item goes straight to the result; a degree query reads the degree
// store; a seed load appends its edge and raises both degrees; an attach draw on a
// non-empty store first runs the remainder unit (2 bits a cycle), reads the chosen edge,
// then appends and raises both degrees. One item is in work at a time; the next is taken in
// the cycle after a result is posted. After reset the degree store is cleared, one entry a
// cycle; no item is taken meanwhile, while register writes are always taken.
module preferential_attachment_edge_generator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  paeg_in_if.sink    in_i,
  paeg_out_if.source out_o,
  paeg_cfg_if.sink   cfg_i
);

  // Sequencer and working registers.
  paeg_pkg::state_e               state_q, state_d;
  paeg_pkg::vtx_addr_t            clr_cnt_q, clr_cnt_d;
  logic [paeg_pkg::OP_W-1:0]      op_q, op_d;
  logic [paeg_pkg::VTX_W-1:0]     va_q, va_d;
  logic [paeg_pkg::VTX_W-1:0]     vb_q, vb_d;
  logic                           pick_q, pick_d;
  logic                           empty_q, empty_d;
  logic                           appended_q, appended_d;
  paeg_pkg::status_e              status_q, status_d;
  logic [paeg_pkg::DEG_W-1:0]     deg_q, deg_d;

  // Architectural state outside the memories.
  paeg_pkg::edge_cnt_t            edge_count_q, edge_count_d;
  logic [paeg_pkg::NV_W-1:0]      nv_q, nv_d;
  logic [paeg_pkg::DRAW_W-1:0]    draws_q, draws_d;
  logic [paeg_pkg::PER_W-1:0]     epn_q, epn_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  paeg_pkg::out_item_t            out_data_q, out_data_d;

  // Memory ports.
  paeg_pkg::edge_word_t           edge_mem [paeg_pkg::MAX_EDGES];
  paeg_pkg::edge_word_t           edge_rdata_q;
  paeg_pkg::edge_word_t           edge_wdata;
  paeg_pkg::edge_addr_t           edge_raddr, edge_waddr;
  logic                           edge_we;
  logic [paeg_pkg::DEG_W-1:0]     deg_mem [paeg_pkg::MAX_VERTICES];
  logic [paeg_pkg::DEG_W-1:0]     deg_rdata_q;
  logic [paeg_pkg::DEG_W-1:0]     deg_wdata;
  paeg_pkg::vtx_addr_t            deg_raddr, deg_waddr;
  logic                           deg_we;

  // Remainder unit.
  logic                           div_start;
  logic                           div_done;
  paeg_pkg::edge_cnt_t            div_rem;

  // Helpers.
  logic                           in_fire, cfg_fire;
  logic [paeg_pkg::PER_W-1:0]     per;
  logic [paeg_pkg::PER_W-1:0]     draws_next;
  logic [paeg_pkg::DEG_W-1:0]     deg_inc;
  logic                           store_full;

  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_fire   = cfg_i.valid && cfg_i.ready;
  assign in_i.ready = (state_q == paeg_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign store_full = (edge_count_q == paeg_pkg::EC_W'(paeg_pkg::MAX_EDGES));
  assign deg_inc    = (deg_rdata_q == '1) ? deg_rdata_q : deg_rdata_q + 1'b1;
  assign draws_next = {1'b0, draws_q} + 1'b1;

  // Draws per vertex, held to the supported range.
  always_comb begin
    per = epn_q;
    if (epn_q < paeg_pkg::PER_MIN) begin
      per = paeg_pkg::PER_MIN;
    end else if (epn_q > paeg_pkg::PER_MAX) begin
      per = paeg_pkg::PER_MAX;
    end
  end

  paeg_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.data.random_word),
    .divisor_i  (edge_count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Next state, memory control and result formation.
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    op_d         = op_q;
    va_d         = va_q;
    vb_d         = vb_q;
    pick_d       = pick_q;
    empty_d      = empty_q;
    appended_d   = appended_q;
    status_d     = status_q;
    deg_d        = deg_q;
    edge_count_d = edge_count_q;
    nv_d         = nv_q;
    draws_d      = draws_q;
    epn_d        = epn_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;
    edge_we      = 1'b0;
    edge_waddr   = paeg_pkg::edge_addr_t'(edge_count_q);
    edge_wdata   = '{first_end: va_q, second_end: vb_q};
    edge_raddr   = paeg_pkg::edge_addr_t'(div_rem);
    deg_we       = 1'b0;
    deg_waddr    = paeg_pkg::vtx_addr_t'(va_q);
    deg_wdata    = deg_inc;
    deg_raddr    = paeg_pkg::vtx_addr_t'(va_q);
    div_start    = 1'b0;

    case (state_q)
      // Sweep the degree store to zero after reset.
      paeg_pkg::ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_cnt_q;
        deg_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = paeg_pkg::ST_IDLE;
        end
      end

      // Take an item, check the limits and pick the work sequence.
      paeg_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d       = in_i.data.operation;
          va_d       = in_i.data.end_a;
          vb_d       = in_i.data.end_b;
          pick_d     = in_i.data.pick_first;
          empty_d    = 1'b0;
          appended_d = 1'b0;
          status_d   = paeg_pkg::STATUS_DONE;
          deg_d      = '0;
          state_d    = paeg_pkg::ST_FINISH;
          case (in_i.data.operation)
            paeg_pkg::OP_SEED: begin
              if (32'(in_i.data.end_a) >= paeg_pkg::MAX_VERTICES ||
                  32'(in_i.data.end_b) >= paeg_pkg::MAX_VERTICES) begin
                status_d = paeg_pkg::STATUS_LIMIT;
              end else if (store_full) begin
                status_d = paeg_pkg::STATUS_FULL;
              end else begin
                state_d = paeg_pkg::ST_APPEND;
              end
            end
            paeg_pkg::OP_ATTACH: begin
              va_d = paeg_pkg::VTX_W'(nv_q);
              if (32'(nv_q) >= paeg_pkg::MAX_VERTICES) begin
                status_d = paeg_pkg::STATUS_LIMIT;
              end else if (store_full) begin
                status_d = paeg_pkg::STATUS_FULL;
              end else if (edge_count_q == '0) begin
                vb_d    = '0;
                empty_d = 1'b1;
                state_d = paeg_pkg::ST_APPEND;
              end else begin
                div_start = 1'b1;
                state_d   = paeg_pkg::ST_DIV;
              end
            end
            paeg_pkg::OP_DEGREE: begin
              if (32'(in_i.data.end_a) >= paeg_pkg::MAX_VERTICES) begin
                status_d = paeg_pkg::STATUS_LIMIT;
              end else begin
                state_d = paeg_pkg::ST_QUERY_RD;
              end
            end
            default: begin
              state_d = paeg_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // Wait for the picked edge index.
      paeg_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = paeg_pkg::ST_EDGE_RD;
        end
      end

      paeg_pkg::ST_EDGE_RD: begin
        edge_raddr = paeg_pkg::edge_addr_t'(div_rem);
        state_d    = paeg_pkg::ST_EDGE_DATA;
      end

      // The chosen endpoint becomes the attach target.
      paeg_pkg::ST_EDGE_DATA: begin
        vb_d    = pick_q ? edge_rdata_q.first_end : edge_rdata_q.second_end;
        state_d = paeg_pkg::ST_APPEND;
      end

      // Append the edge and, for an attach draw, advance the growing vertex once its draws are done.
      paeg_pkg::ST_APPEND: begin
        edge_we      = 1'b1;
        edge_count_d = edge_count_q + 1'b1;
        appended_d   = 1'b1;
        if (op_q == paeg_pkg::OP_ATTACH) begin
          if (empty_q || draws_next >= per) begin
            nv_d    = nv_q + 1'b1;
            draws_d = '0;
          end else begin
            draws_d = draws_next[paeg_pkg::DRAW_W-1:0];
          end
        end
        state_d = paeg_pkg::ST_DEG_RD_A;
      end

      // Raise both degrees one after the other, so a self loop counts twice.
      paeg_pkg::ST_DEG_RD_A: begin
        deg_raddr = paeg_pkg::vtx_addr_t'(va_q);
        state_d   = paeg_pkg::ST_DEG_WR_A;
      end

      paeg_pkg::ST_DEG_WR_A: begin
        deg_we    = 1'b1;
        deg_waddr = paeg_pkg::vtx_addr_t'(va_q);
        state_d   = paeg_pkg::ST_DEG_RD_B;
      end

      paeg_pkg::ST_DEG_RD_B: begin
        deg_raddr = paeg_pkg::vtx_addr_t'(vb_q);
        state_d   = paeg_pkg::ST_DEG_WR_B;
      end

      paeg_pkg::ST_DEG_WR_B: begin
        deg_we    = 1'b1;
        deg_waddr = paeg_pkg::vtx_addr_t'(vb_q);
        if (op_q == paeg_pkg::OP_ATTACH) begin
          deg_d = deg_inc;
        end
        state_d = paeg_pkg::ST_FINISH;
      end

      paeg_pkg::ST_QUERY_RD: begin
        deg_raddr = paeg_pkg::vtx_addr_t'(va_q);
        state_d   = paeg_pkg::ST_QUERY_DATA;
      end

      paeg_pkg::ST_QUERY_DATA: begin
        deg_d   = deg_rdata_q;
        state_d = paeg_pkg::ST_FINISH;
      end

      // Post the result once the result register is free.
      paeg_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = status_q;
          out_data_d.edge_from  = appended_q ? va_q : '0;
          out_data_d.edge_to    = appended_q ? vb_q : '0;
          out_data_d.degree     = deg_q;
          out_data_d.edge_total = paeg_pkg::TOTAL_W'(edge_count_q);
          state_d               = paeg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = paeg_pkg::ST_IDLE;
      end
    endcase

    // Register writes.
    if (cfg_fire) begin
      case (cfg_i.data.index)
        paeg_pkg::REG_SEED_NODES: begin
          nv_d    = cfg_i.data.value[paeg_pkg::NV_W-1:0];
          draws_d = '0;
        end
        paeg_pkg::REG_EDGES_PER_NODE: begin
          epn_d = cfg_i.data.value[paeg_pkg::PER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= paeg_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      edge_count_q <= '0;
      nv_q         <= paeg_pkg::SEED_NODES_RESET;
      draws_q      <= '0;
      epn_q        <= paeg_pkg::EDGES_PER_NODE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      edge_count_q <= edge_count_d;
      nv_q         <= nv_d;
      draws_q      <= draws_d;
      epn_q        <= epn_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    pick_q     <= pick_d;
    empty_q    <= empty_d;
    appended_q <= appended_d;
    status_q   <= status_d;
    deg_q      <= deg_d;
    out_data_q <= out_data_d;
  end

  // Edge store.
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata_q <= edge_mem[edge_raddr];
  end

  // Degree store.
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rdata_q <= deg_mem[deg_raddr];
  end

endmodule

FILE: rtl/core/paeg_checker.sv
// Port-level checker for the graph generator and its bind to the top level.
module paeg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input paeg_pkg::out_item_t out_data_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending_q, pending_d;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Items accepted whose result has not been taken yet.
  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A posted result waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before its transaction");

  // Every result belongs to an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pending_q != 2'd0))
    else $error("result without an accepted item");

  // At most one item in work and one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |-> (pending_q < 2'd2))
    else $error("item accepted while two are outstanding");

  // A refused item reports no edge and no degree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.status != paeg_pkg::STATUS_DONE) |->
      (out_data_i.edge_from == '0 && out_data_i.edge_to == '0 &&
       out_data_i.degree == '0))
    else $error("refused item carries edge or degree");

endmodule

bind preferential_attachment_edge_generator_core paeg_checker u_paeg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: verif/preferential_attachment_edge_generator_core_test.sv
// Self-checking testbench of the preferential attachment edge generator core.
`timescale 1ns / 1ps

module preferential_attachment_edge_generator_core_test;

  // Codes the block must ignore: a fourth operation and an unmapped register.
  localparam logic [paeg_pkg::OP_W-1:0]      OP_UNUSED  = paeg_pkg::OP_W'(3);
  localparam logic [paeg_pkg::CFG_IDX_W-1:0] REG_UNUSED = paeg_pkg::CFG_IDX_W'(3);

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [paeg_pkg::VTX_W-1:0] LOOP_VERTEX = paeg_pkg::VTX_W'(9);

  // Tracks the graph as it should grow and holds the results still owed by the block.
  class graph_growth_scoreboard;
    logic [paeg_pkg::VTX_W-1:0] first_end [paeg_pkg::MAX_EDGES];
    logic [paeg_pkg::VTX_W-1:0] second_end [paeg_pkg::MAX_EDGES];
    logic [paeg_pkg::DEG_W-1:0] degree_of [paeg_pkg::MAX_VERTICES];
    int unsigned edge_total;
    int unsigned grow_vertex;
    int unsigned draws_done;
    int unsigned draws_per_vertex;
    int unsigned mismatch_count;
    paeg_pkg::out_item_t expected_results[$];

    function new();
      foreach (degree_of[i]) degree_of[i] = '0;
      edge_total = 0;
      grow_vertex = paeg_pkg::SEED_NODES_RESET;
      draws_done = 0;
      draws_per_vertex = paeg_pkg::EDGES_PER_NODE_RESET;
      mismatch_count = 0;
    endfunction

    // Degree counters stop at their top value.
    function void raise_degree(int unsigned v);
      if (degree_of[v] != '1) degree_of[v] = degree_of[v] + 1'b1;
    endfunction

    function void append_edge(int unsigned a, int unsigned b);
      first_end[edge_total] = paeg_pkg::VTX_W'(a);
      second_end[edge_total] = paeg_pkg::VTX_W'(b);
      edge_total++;
      raise_degree(a);
      raise_degree(b);
    endfunction

    function void note_register(logic [paeg_pkg::CFG_IDX_W-1:0] index,
                                logic [paeg_pkg::CFG_DATA_W-1:0] value);
      if (index == paeg_pkg::REG_SEED_NODES) begin
        grow_vertex = value[paeg_pkg::NV_W-1:0];
        draws_done = 0;
      end else if (index == paeg_pkg::REG_EDGES_PER_NODE) begin
        draws_per_vertex = value[paeg_pkg::PER_W-1:0];
      end
    endfunction

    // Works out the result of one accepted transaction and updates the graph.
    function void note_item(paeg_pkg::in_item_t item);
      paeg_pkg::out_item_t res;
      int unsigned per;
      int unsigned pick;
      int unsigned target;
      bit          empty_store;
      per = draws_per_vertex;
      if (per < paeg_pkg::PER_MIN) per = paeg_pkg::PER_MIN;
      if (per > paeg_pkg::PER_MAX) per = paeg_pkg::PER_MAX;
      res = '0;
      case (item.operation)
        paeg_pkg::OP_SEED: begin
          if (edge_total >= paeg_pkg::MAX_EDGES) begin
            res.status = paeg_pkg::STATUS_FULL;
          end else begin
            append_edge(item.end_a, item.end_b);
            res.edge_from = item.end_a;
            res.edge_to = item.end_b;
          end
        end
        paeg_pkg::OP_ATTACH: begin
          if (grow_vertex >= paeg_pkg::MAX_VERTICES) begin
            res.status = paeg_pkg::STATUS_LIMIT;
          end else if (edge_total >= paeg_pkg::MAX_EDGES) begin
            res.status = paeg_pkg::STATUS_FULL;
          end else begin
            // An empty store attaches to vertex zero and finishes the vertex at once.
            empty_store = (edge_total == 0);
            target = 0;
            if (!empty_store) begin
              pick = item.random_word % edge_total;
              target = item.pick_first ? first_end[pick] : second_end[pick];
            end
            append_edge(grow_vertex, target);
            res.edge_from = paeg_pkg::VTX_W'(grow_vertex);
            res.edge_to = paeg_pkg::VTX_W'(target);
            res.degree = degree_of[target];
            draws_done++;
            if (empty_store || draws_done >= per) begin
              draws_done = 0;
              grow_vertex++;
            end
          end
        end
        paeg_pkg::OP_DEGREE: begin
          res.degree = degree_of[item.end_a];
        end
        default: ;
      endcase
      res.edge_total = paeg_pkg::TOTAL_W'(edge_total);
      expected_results = {expected_results, res};
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(paeg_pkg::out_item_t got);
      paeg_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d from %0d to %0d degree %0d total %0d",
                   got.status, got.edge_from, got.edge_to, got.degree, got.edge_total);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.edge_from !== want.edge_from ||
          got.edge_to !== want.edge_to || got.degree !== want.degree ||
          got.edge_total !== want.edge_total) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("mismatch: expected status %0d from %0d to %0d degree %0d total %0d",
                   want.status, want.edge_from, want.edge_to, want.degree, want.edge_total);
          $display("          got status %0d from %0d to %0d degree %0d total %0d",
                   got.status, got.edge_from, got.edge_to, got.degree, got.edge_total);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  paeg_in_if  in_if ();
  paeg_out_if out_if ();
  paeg_cfg_if cfg_if ();

  graph_growth_scoreboard growth;
  int unsigned in_max_gap;
  int unsigned out_max_gap;
  int unsigned cycle_count = 0;

  preferential_attachment_edge_generator_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("preferential_attachment_edge_generator_core test failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transaction.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, out_max_gap);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      growth.check_result(out_if.data);
  end

  function automatic paeg_pkg::in_item_t make_item(logic [paeg_pkg::OP_W-1:0] op,
                                                   logic [paeg_pkg::VTX_W-1:0] a,
                                                   logic [paeg_pkg::VTX_W-1:0] b,
                                                   logic [paeg_pkg::RND_W-1:0] rnd,
                                                   logic first);
    paeg_pkg::in_item_t item;
    item.operation = op;
    item.end_a = a;
    item.end_b = b;
    item.random_word = rnd;
    item.pick_first = first;
    return item;
  endfunction

  // Mostly a small set of hub vertices so that degrees build up, plus the extremes.
  function automatic logic [paeg_pkg::VTX_W-1:0] random_vertex();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5, 6: return paeg_pkg::VTX_W'($urandom_range(0, 63));
      default: return paeg_pkg::VTX_W'($urandom_range(0, paeg_pkg::MAX_VERTICES - 1));
    endcase
  endfunction

  // Sends one input transaction after a random gap; valid stays high afterwards.
  task automatic send_item(paeg_pkg::in_item_t item);
    int unsigned gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= item;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    growth.note_item(item);
  endtask

  task automatic write_register(logic [paeg_pkg::CFG_IDX_W-1:0] index,
                                logic [paeg_pkg::CFG_DATA_W-1:0] value);
    paeg_pkg::cfg_write_t wr;
    wr.index = index;
    wr.value = value;
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= wr;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    growth.note_register(index, value);
    cfg_if.valid <= 1'b0;
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (growth.expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    paeg_pkg::in_item_t item;
    int unsigned roll;
    int unsigned phase_seed;
    int unsigned phase_per;
    int unsigned phase_count;
    growth = new();
    in_max_gap = 16;
    out_max_gap = 16;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A write to an unmapped register must change nothing.
    write_register(REG_UNUSED, paeg_pkg::CFG_DATA_W'($urandom));

    // Directed part at the reset settings: empty store, extremes, self loops.
    send_item(make_item(paeg_pkg::OP_DEGREE, '0, '0, '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_DEGREE, '1, '0, '0, 1'b0));
    send_item(make_item(OP_UNUSED, '1, '1, '1, 1'b1));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b1));
    send_item(make_item(paeg_pkg::OP_SEED, '0, '1, '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_SEED, '1, '1, '1, 1'b1));
    send_item(make_item(paeg_pkg::OP_SEED, 14'h2AAA, 14'h1555, 32'h5555_5555, 1'b0));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, '0, 1'b1));
    send_item(make_item(paeg_pkg::OP_ATTACH, '1, '1, '1, 1'b0));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, 32'h8000_0000, 1'b1));
    send_item(make_item(paeg_pkg::OP_DEGREE, '1, '0, '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_DEGREE, '0, '0, '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_DEGREE, paeg_pkg::VTX_W'(101), '0, '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_SEED, paeg_pkg::VTX_W'(101), paeg_pkg::VTX_W'(101),
                        '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_DEGREE, paeg_pkg::VTX_W'(101), '0, '0, 1'b0));

    // Last grown vertex, then the vertex limit.
    wait_drained();
    write_register(paeg_pkg::REG_SEED_NODES,
                   paeg_pkg::CFG_DATA_W'(paeg_pkg::MAX_VERTICES - 1));
    write_register(paeg_pkg::REG_EDGES_PER_NODE, paeg_pkg::CFG_DATA_W'(paeg_pkg::PER_MIN));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b0));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b1));
    send_item(make_item(paeg_pkg::OP_SEED, paeg_pkg::VTX_W'(3), paeg_pkg::VTX_W'(4),
                        '0, 1'b0));
    send_item(make_item(paeg_pkg::OP_DEGREE, '1, '0, '0, 1'b0));
    wait_drained();
    write_register(paeg_pkg::REG_SEED_NODES, paeg_pkg::CFG_DATA_W'(paeg_pkg::MAX_VERTICES));
    write_register(paeg_pkg::REG_EDGES_PER_NODE, paeg_pkg::CFG_DATA_W'(paeg_pkg::PER_MAX));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b1));

    // Random part, one register setting per phase.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin phase_seed = 0;     phase_per = 1;  phase_count = 200; end
        1: begin phase_seed = 16380; phase_per = 8;  phase_count = 120; end
        2: begin phase_seed = 300;   phase_per = 0;  phase_count = 200; end
        3: begin phase_seed = 2000;  phase_per = 15; phase_count = 220; end
        4: begin phase_seed = 16384; phase_per = 4;  phase_count = 40;  end
        5: begin phase_seed = 32767; phase_per = 9;  phase_count = 30;  end
        default: begin phase_seed = 7; phase_per = 5; phase_count = 250; end
      endcase
      wait_drained();
      write_register(paeg_pkg::REG_SEED_NODES, paeg_pkg::CFG_DATA_W'(phase_seed));
      // Upper data bits are random; only the low four belong to the register.
      write_register(paeg_pkg::REG_EDGES_PER_NODE,
                     paeg_pkg::CFG_DATA_W'(($urandom & 32'h7FF0) | phase_per));
      in_max_gap = (p == 3) ? 0 : 16;
      out_max_gap = (p == 3) ? 0 : 16;
      repeat (phase_count) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) item.operation = paeg_pkg::OP_ATTACH;
        else if (roll < 75) item.operation = paeg_pkg::OP_SEED;
        else if (roll < 95) item.operation = paeg_pkg::OP_DEGREE;
        else item.operation = OP_UNUSED;
        item.end_a = random_vertex();
        item.end_b = random_vertex();
        // Some queries look at the vertex that was grown last.
        if (item.operation == paeg_pkg::OP_DEGREE && $urandom_range(0, 3) == 0)
          item.end_a = paeg_pkg::VTX_W'(growth.grow_vertex - 1);
        case ($urandom_range(0, 7))
          0: item.random_word = '0;
          1: item.random_word = '1;
          2: item.random_word = paeg_pkg::RND_W'($urandom_range(0, 255));
          default: item.random_word = $urandom;
        endcase
        item.pick_first = $urandom_range(0, 1);
        send_item(item);
      end
    end

    // Closing items: a self loop, a draw, the degree of the loop vertex and an unknown operation.
    in_max_gap = 16;
    out_max_gap = 16;
    send_item(make_item(paeg_pkg::OP_SEED, LOOP_VERTEX, LOOP_VERTEX, $urandom, 1'b0));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b1));
    send_item(make_item(paeg_pkg::OP_DEGREE, LOOP_VERTEX, '0, '0, 1'b0));
    send_item(make_item(OP_UNUSED, paeg_pkg::VTX_W'($urandom), paeg_pkg::VTX_W'($urandom),
                        $urandom, 1'b0));
    // A draw past the last vertex is refused.
    wait_drained();
    write_register(paeg_pkg::REG_SEED_NODES, paeg_pkg::CFG_DATA_W'(paeg_pkg::MAX_VERTICES));
    send_item(make_item(paeg_pkg::OP_ATTACH, '0, '0, $urandom, 1'b0));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (growth.mismatch_count == 0 && growth.expected_results.size() == 0) begin
      $display("preferential_attachment_edge_generator_core test passed");
    end else begin
      $display("preferential_attachment_edge_generator_core test failed");
    end
    $finish;
  end

endmodule
